// File: rtl/sac_pkg.sv
`timescale 1ns / 1ps

package sac_pkg;

    // field widths
    localparam int OP_W       = 3;
    localparam int SEQ_W      = 8;
    localparam int STATUS_W   = 2;
    localparam int PHASE_W    = 2;
    localparam int ACK_WAIT_W = 16;
    localparam int TICK_SHIFT = 4;
    localparam int WAIT_W     = ACK_WAIT_W - TICK_SHIFT;

    // ack wait after reset, in microseconds
    localparam logic [ACK_WAIT_W-1:0] ACK_WAIT_RESET = ACK_WAIT_W'(864);

    // event codes
    localparam logic [OP_W-1:0] OP_SEND        = OP_W'(0);
    localparam logic [OP_W-1:0] OP_SEND_DONE   = OP_W'(1);
    localparam logic [OP_W-1:0] OP_TICK        = OP_W'(2);
    localparam logic [OP_W-1:0] OP_RECEIVE     = OP_W'(3);
    localparam logic [OP_W-1:0] OP_LOWER_READY = OP_W'(4);

    // phase codes
    localparam logic [PHASE_W-1:0] PH_READY   = PHASE_W'(0);
    localparam logic [PHASE_W-1:0] PH_DATA    = PHASE_W'(1);
    localparam logic [PHASE_W-1:0] PH_WAIT    = PHASE_W'(2);
    localparam logic [PHASE_W-1:0] PH_ACKSEND = PHASE_W'(3);

    // send request answers
    localparam logic [STATUS_W-1:0] SEND_ACCEPTED = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] SEND_BUSY     = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] SEND_REFUSED  = STATUS_W'(2);

    // one input event
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic             lower_accepts;
        logic             lower_ok;
        logic             wants_ack;
        logic [SEQ_W-1:0] seq_num;
        logic             is_ack;
        logic             needs_reply;
    } sac_req_t;

    // one result
    typedef struct packed {
        logic [STATUS_W-1:0] send_status;
        logic                issue_ack;
        logic [SEQ_W-1:0]    ack_seq;
        logic                done_res;
        logic                done_failed;
        logic                was_acked;
        logic                pass_up;
        logic                dropped;
        logic                ready_up;
        logic [PHASE_W-1:0]  phase;
    } sac_rsp_t;

    // controller state
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [SEQ_W-1:0]   tx_seq;
        logic               tx_wants_ack;
        logic [WAIT_W-1:0]  wait_count;
    } sac_state_t;

endpackage

// File: rtl/sac_core.sv
`timescale 1ns / 1ps

module sac_core (
    input  sac_pkg::sac_state_t                   state,
    input  sac_pkg::sac_req_t                     item,
    input  logic [sac_pkg::ACK_WAIT_W-1:0]        ack_wait,
    output sac_pkg::sac_state_t                   state_next,
    output sac_pkg::sac_rsp_t                     result
);

    import sac_pkg::*;

    // event decode and state update
    always_comb
    begin
        state_next = state;
        result     = '0;
        case (item.op)
            OP_SEND:
            begin
                if (state.phase != PH_READY)
                begin
                    result.send_status = SEND_BUSY;
                end
                else if (!item.lower_accepts)
                begin
                    result.send_status = SEND_REFUSED;
                end
                else
                begin
                    result.send_status      = SEND_ACCEPTED;
                    state_next.phase        = PH_DATA;
                    state_next.tx_seq       = item.seq_num;
                    state_next.tx_wants_ack = item.wants_ack;
                end
            end
            OP_SEND_DONE:
            begin
                if (state.phase == PH_ACKSEND)
                begin
                    state_next.phase = PH_READY;
                end
                else if (state.phase == PH_DATA)
                begin
                    if (item.lower_ok && state.tx_wants_ack)
                    begin
                        // countdown in 16 us ticks
                        state_next.wait_count = ack_wait[ACK_WAIT_W-1:TICK_SHIFT];
                        state_next.phase      = PH_WAIT;
                    end
                    else
                    begin
                        state_next.phase   = PH_READY;
                        result.done_res    = 1'b1;
                        result.done_failed = !item.lower_ok;
                    end
                end
            end
            OP_TICK:
            begin
                if (state.phase == PH_WAIT)
                begin
                    if (state.wait_count <= WAIT_W'(1))
                    begin
                        // ack wait timed out
                        state_next.wait_count = '0;
                        state_next.phase      = PH_READY;
                        result.done_res       = 1'b1;
                    end
                    else
                    begin
                        state_next.wait_count = state.wait_count - WAIT_W'(1);
                    end
                end
            end
            OP_RECEIVE:
            begin
                if (state.phase == PH_READY || state.phase == PH_WAIT)
                begin
                    if (item.is_ack)
                    begin
                        if (state.phase == PH_WAIT && item.seq_num == state.tx_seq)
                        begin
                            state_next.wait_count = '0;
                            state_next.phase      = PH_READY;
                            result.done_res       = 1'b1;
                            result.was_acked      = 1'b1;
                        end
                        else
                        begin
                            result.dropped = 1'b1;
                        end
                    end
                    else
                    begin
                        // reply with an ack when ready, a reply is needed and lower can take it
                        if (state.phase == PH_READY && item.needs_reply
                            && item.lower_accepts)
                        begin
                            state_next.phase = PH_ACKSEND;
                            result.issue_ack = 1'b1;
                            result.ack_seq   = item.seq_num;
                        end
                        result.pass_up = 1'b1;
                    end
                end
            end
            OP_LOWER_READY:
            begin
                result.ready_up = (state.phase == PH_READY);
            end
            default:
            begin
                state_next = state;
            end
        endcase
        result.phase = state_next.phase;
    end

endmodule

// File: rtl/software_ack_controller.sv
`timescale 1ns / 1ps

// Software ack controller for an 802.15.4 style link layer. Each event
// transaction on req yields exactly one result transaction on rsp. An event
// is captured in an input register, decoded against the controller state and
// written to a result register, whose output is valid on rsp; one event per
// cycle is sustained unless rsp_stall holds a full result register. The input
// register keeps taking an event while a finished result waits on rsp_stall;
// req_stall rises only when both registers are full. The ack wait (cfg_data,
// microseconds) is loaded as a countdown of ack_wait/16 ticks when a successful
// data send that asked for an ack completes; write it only while no transaction
// is in flight. Reset value of the ack wait is 864 us.
module software_ack_controller (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  sac_pkg::sac_req_t                 req,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output sac_pkg::sac_rsp_t                 rsp,
    input  logic                              cfg_write,
    input  logic [sac_pkg::ACK_WAIT_W-1:0]    cfg_data
);

    import sac_pkg::*;

    logic                  req_valid_reg;
    sac_req_t              req_reg;
    logic                  rsp_valid_reg;
    sac_rsp_t              rsp_reg;
    sac_state_t            state_reg;
    sac_state_t            state_next;
    sac_rsp_t              rsp_next;
    logic [ACK_WAIT_W-1:0] ack_wait_reg;
    logic                  advance;
    logic                  req_take;

    // pipeline flow control
    assign advance   = req_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = req_valid_reg && !advance;
    assign req_take  = req_valid && !req_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_wait_reg <= ACK_WAIT_RESET;
        end
        else if (cfg_write)
        begin
            ack_wait_reg <= cfg_data;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (req_take)
        begin
            req_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            req_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            req_reg <= req;
        end
    end

    // event decode
    sac_core u_core (
        .state      (state_reg),
        .item       (req_reg),
        .ack_wait   (ack_wait_reg),
        .state_next (state_next),
        .result     (rsp_next)
    );

    // controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

`ifndef ASSERT_OFF
    // waiting for an ack only happens for frames that asked for one
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_WAIT |-> state_reg.tx_wants_ack)
    else $error("ack wait entered for a frame without ack request");

    // a reported completion leaves the controller ready
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && rsp_next.done_res |=> state_reg.phase == PH_READY)
    else $error("completion reported but controller not ready");

    // the reported phase follows the state just written
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> rsp_reg.phase == state_reg.phase)
    else $error("reported phase differs from controller state");

    // input side only stalls while holding an event that cannot move
    assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> req_valid_reg && rsp_valid_reg && rsp_stall)
    else $error("input stalled without a blocked result");
`endif

endmodule
